// ===== sv/box_filter_downsample_macros.svh =====
// Assertion shorthands for the box filter downsampler checks.
`ifndef BOX_FILTER_DOWNSAMPLE_MACROS_SVH
`define BOX_FILTER_DOWNSAMPLE_MACROS_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define BFD_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BFD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/bfd_pkg.sv =====
package bfd_pkg;

   localparam int MAX_OUT_WIDTH = 1024;
   localparam int MAX_FACTOR    = 4;

   localparam int NCHAN     = 4;
   localparam int CHAN_W    = 8;
   localparam int FACTOR_W  = 3;
   localparam int WIDTH_W   = 11;
   localparam int COL_W     = $clog2(MAX_OUT_WIDTH);
   localparam int SUB_W     = $clog2(MAX_FACTOR);
   localparam int RUN_W     = $clog2(MAX_FACTOR * 255 + 1);
   localparam int SUM_W     = $clog2(MAX_FACTOR * MAX_FACTOR * 255 + 1);
   localparam int COLSUM_W  = NCHAN * SUM_W;

   localparam int FACTOR_RESET = 1;
   localparam int WIDTH_RESET  = 1024;

   // x / 9 == (x * 3641) >> 15 for every x below 2**SUM_W
   localparam int RECIP9       = 3641;
   localparam int RECIP_W      = 12;
   localparam int RECIP_SHIFT  = 15;

   localparam int FIFO_DEPTH   = 4;
   localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 11;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FACTOR    = 2'd0,
      CSR_OUT_WIDTH = 2'd1
   } csr_reg_type;

   // effective factor minus one
   typedef enum logic [SUB_W-1:0] {
      SCALE_1X = 2'd0,
      SCALE_2X = 2'd1,
      SCALE_3X = 2'd2,
      SCALE_4X = 2'd3
   } scale_type;

   typedef logic [NCHAN-1:0][CHAN_W-1:0] pixel_type;
   typedef logic [NCHAN-1:0][RUN_W-1:0]  run_type;
   typedef logic [NCHAN-1:0][SUM_W-1:0]  colsum_type;

   typedef struct packed {
      logic      row_end;
      pixel_type chan;
   } rsp_word_type;

   // block sum divided by factor squared, low byte kept
   function automatic logic [CHAN_W-1:0] avg_div(input logic [SUM_W-1:0] sum,
                                                 input scale_type scale);
      logic [SUM_W+RECIP_W-1:0] prod;
      logic [CHAN_W-1:0]        q;
      prod = (SUM_W+RECIP_W)'(sum) * (SUM_W+RECIP_W)'(RECIP9);
      unique case (scale)
         SCALE_1X: q = sum[CHAN_W-1:0];
         SCALE_2X: q = sum[CHAN_W+1:2];
         SCALE_3X: q = prod[RECIP_SHIFT+CHAN_W-1:RECIP_SHIFT];
         SCALE_4X: q = sum[CHAN_W+3:4];
         default:  q = sum[CHAN_W-1:0];
      endcase
      return q;
   endfunction

endpackage

// ===== sv/bfd_channels.sv =====
interface bfd_req_if;
   logic                        valid;
   logic                        ready;
   logic [bfd_pkg::CHAN_W-1:0]  in_red;
   logic [bfd_pkg::CHAN_W-1:0]  in_green;
   logic [bfd_pkg::CHAN_W-1:0]  in_blue;
   logic [bfd_pkg::CHAN_W-1:0]  in_alpha;
   logic                        frame_start;

   modport source(output valid, in_red, in_green, in_blue, in_alpha, frame_start,
                  input ready);
   modport sink(input valid, in_red, in_green, in_blue, in_alpha, frame_start,
                output ready);
endinterface

interface bfd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [bfd_pkg::CHAN_W-1:0]  out_red;
   logic [bfd_pkg::CHAN_W-1:0]  out_green;
   logic [bfd_pkg::CHAN_W-1:0]  out_blue;
   logic [bfd_pkg::CHAN_W-1:0]  out_alpha;
   logic                        row_end;

   modport source(output valid, out_red, out_green, out_blue, out_alpha, row_end,
                  input ready);
   modport sink(input valid, out_red, out_green, out_blue, out_alpha, row_end,
                output ready);
endinterface

interface bfd_csr_if;
   logic                           valid;
   logic                           ready;
   logic [bfd_pkg::CSR_IDX_W-1:0]  index;
   logic [bfd_pkg::CSR_DATA_W-1:0] data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

// ===== sv/bfd_ram.sv =====
module bfd_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== sv/box_filter_downsample.sv =====
// A result passes the RAM and divide stages into the result queue once its block is complete.
// Throughput: one pixel per clock while req ready is high; each pixel that closes a block
// row does one read-modify-write of the column-sum RAM (read, then add and write in the next
// cycle, forwarded). req ready drops while 4 results are in flight or waiting to be taken.
// Reset: position counters and running sums clear, factor = 1, out_width = 1024.
// The column-sum RAM is not cleared; the first block row of each band overwrites it.
module box_filter_downsample (
   input  logic         clock,
   input  logic         reset,
   bfd_req_if.sink      req_chan,
   bfd_rsp_if.source    rsp_chan,
   bfd_csr_if.sink      csr_chan
);

   // configuration
   logic [bfd_pkg::FACTOR_W-1:0]   factor_ff;
   logic [bfd_pkg::WIDTH_W-1:0]    out_width_ff;
   logic [bfd_pkg::FACTOR_W-1:0]   f_eff;
   logic [bfd_pkg::WIDTH_W-1:0]    w_eff;
   bfd_pkg::scale_type             scale;

   // position state
   logic [bfd_pkg::SUB_W-1:0]      sub_column_ff, sub_column_in;
   logic [bfd_pkg::SUB_W-1:0]      sub_row_ff, sub_row_in;
   logic [bfd_pkg::COL_W-1:0]      out_column_ff, out_column_in;
   bfd_pkg::run_type               run_sum_ff, run_sum_in;

   // accept stage
   logic                           accept;
   bfd_pkg::pixel_type             pix;
   logic [bfd_pkg::SUB_W-1:0]      sc, sr;
   logic [bfd_pkg::COL_W-1:0]      oc, col;
   bfd_pkg::run_type               run_add;
   logic                           done, last_col, row_last;

   // RAM stage
   logic                           b_valid_ff;
   logic [bfd_pkg::COL_W-1:0]      b_col_ff;
   bfd_pkg::run_type               b_run_ff;
   logic                           b_first_ff, b_emit_ff, b_row_end_ff;
   bfd_pkg::scale_type             b_scale_ff;
   logic [bfd_pkg::COLSUM_W-1:0]   rd_data;
   bfd_pkg::colsum_type            b_base, b_sum;
   logic                           fwd;

   // last write, for read-during-write on the same column
   logic                           wl_valid_ff;
   logic [bfd_pkg::COL_W-1:0]      wl_addr_ff;
   bfd_pkg::colsum_type            wl_data_ff;

   // divide stage
   logic                           c_valid_ff;
   bfd_pkg::colsum_type            c_sum_ff;
   bfd_pkg::scale_type             c_scale_ff;
   logic                           c_row_end_ff;
   bfd_pkg::rsp_word_type          c_word;

   // result queue
   bfd_pkg::rsp_word_type          fifo_ff [bfd_pkg::FIFO_DEPTH];
   logic [bfd_pkg::FIFO_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [bfd_pkg::FIFO_CNT_W-1:0] fifo_cnt_ff;
   logic [bfd_pkg::FIFO_CNT_W:0]   pending;
   logic                           pop;
   bfd_pkg::rsp_word_type          head;

   // ---------------- configuration ----------------
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff    <= bfd_pkg::FACTOR_W'(bfd_pkg::FACTOR_RESET);
         out_width_ff <= bfd_pkg::WIDTH_W'(bfd_pkg::WIDTH_RESET);
      end else if (csr_chan.valid && csr_chan.ready) begin
         unique case (bfd_pkg::csr_reg_type'(csr_chan.index))
            bfd_pkg::CSR_FACTOR:    factor_ff    <= csr_chan.data[bfd_pkg::FACTOR_W-1:0];
            bfd_pkg::CSR_OUT_WIDTH: out_width_ff <= csr_chan.data[bfd_pkg::WIDTH_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (factor_ff == '0) begin
         f_eff = bfd_pkg::FACTOR_W'(1);
      end else if (factor_ff > bfd_pkg::FACTOR_W'(bfd_pkg::MAX_FACTOR)) begin
         f_eff = bfd_pkg::FACTOR_W'(bfd_pkg::MAX_FACTOR);
      end else begin
         f_eff = factor_ff;
      end
      if (out_width_ff == '0) begin
         w_eff = bfd_pkg::WIDTH_W'(1);
      end else if (out_width_ff > bfd_pkg::WIDTH_W'(bfd_pkg::MAX_OUT_WIDTH)) begin
         w_eff = bfd_pkg::WIDTH_W'(bfd_pkg::MAX_OUT_WIDTH);
      end else begin
         w_eff = out_width_ff;
      end
   end

   assign scale = bfd_pkg::scale_type'(bfd_pkg::SUB_W'(f_eff - bfd_pkg::FACTOR_W'(1)));

   // ---------------- accept stage ----------------
   assign accept = req_chan.valid && req_chan.ready;
   assign pix    = {req_chan.in_alpha, req_chan.in_blue, req_chan.in_green, req_chan.in_red};

   always_comb begin
      // frame_start restarts the position before the pixel is taken
      sc = req_chan.frame_start ? '0 : sub_column_ff;
      sr = req_chan.frame_start ? '0 : sub_row_ff;
      oc = req_chan.frame_start ? '0 : out_column_ff;
      for (int ch = 0; ch < bfd_pkg::NCHAN; ch++) begin
         run_add[ch] = (req_chan.frame_start ? '0 : run_sum_ff[ch])
                       + bfd_pkg::RUN_W'(pix[ch]);
      end

      done = (bfd_pkg::FACTOR_W'(sc) + bfd_pkg::FACTOR_W'(1)) >= f_eff;
      // a column past the width counts as the last one
      col  = (bfd_pkg::WIDTH_W'(oc) >= w_eff) ?
             bfd_pkg::COL_W'(w_eff - bfd_pkg::WIDTH_W'(1)) : oc;
      last_col = (bfd_pkg::WIDTH_W'(col) + bfd_pkg::WIDTH_W'(1)) >= w_eff;
      row_last = (bfd_pkg::FACTOR_W'(sr) + bfd_pkg::FACTOR_W'(1)) >= f_eff;

      sub_column_in = sub_column_ff;
      sub_row_in    = sub_row_ff;
      out_column_in = out_column_ff;
      run_sum_in    = run_sum_ff;
      if (accept) begin
         if (done) begin
            sub_column_in = '0;
            run_sum_in    = '0;
            if (last_col) begin
               out_column_in = '0;
               sub_row_in    = row_last ? '0 : sr + bfd_pkg::SUB_W'(1);
            end else begin
               out_column_in = col + bfd_pkg::COL_W'(1);
               sub_row_in    = sr;
            end
         end else begin
            sub_column_in = sc + bfd_pkg::SUB_W'(1);
            sub_row_in    = sr;
            out_column_in = oc;
            run_sum_in    = run_add;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_column_ff <= '0;
         sub_row_ff    <= '0;
         out_column_ff <= '0;
         run_sum_ff    <= '0;
         b_valid_ff    <= 1'b0;
         wl_valid_ff   <= 1'b0;
         c_valid_ff    <= 1'b0;
      end else begin
         sub_column_ff <= sub_column_in;
         sub_row_ff    <= sub_row_in;
         out_column_ff <= out_column_in;
         run_sum_ff    <= run_sum_in;
         b_valid_ff    <= accept && done;
         wl_valid_ff   <= b_valid_ff;
         c_valid_ff    <= b_valid_ff && b_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      b_col_ff     <= col;
      b_run_ff     <= run_add;
      b_first_ff   <= (sr == '0);
      b_emit_ff    <= row_last;
      b_row_end_ff <= last_col;
      b_scale_ff   <= scale;
      wl_addr_ff   <= b_col_ff;
      wl_data_ff   <= b_sum;
      c_sum_ff     <= b_sum;
      c_scale_ff   <= b_scale_ff;
      c_row_end_ff <= b_row_end_ff;
   end

   // ---------------- column-sum RAM ----------------
   bfd_ram #(
      .WIDTH(bfd_pkg::COLSUM_W),
      .DEPTH(bfd_pkg::MAX_OUT_WIDTH)
   ) u_colsum_ram (
      .clock   (clock),
      .wr_en   (b_valid_ff),
      .wr_addr (b_col_ff),
      .wr_data (b_sum),
      .rd_en   (accept && done),
      .rd_addr (col),
      .rd_data (rd_data)
   );

   // the read was issued in the cycle of the last write; take that word if it hit
   assign fwd    = wl_valid_ff && (wl_addr_ff == b_col_ff);
   assign b_base = fwd ? wl_data_ff : bfd_pkg::colsum_type'(rd_data);

   always_comb begin
      for (int ch = 0; ch < bfd_pkg::NCHAN; ch++) begin
         b_sum[ch] = (b_first_ff ? '0 : b_base[ch]) + bfd_pkg::SUM_W'(b_run_ff[ch]);
      end
   end

   // ---------------- divide stage ----------------
   always_comb begin
      c_word.row_end = c_row_end_ff;
      for (int ch = 0; ch < bfd_pkg::NCHAN; ch++) begin
         c_word.chan[ch] = bfd_pkg::avg_div(c_sum_ff[ch], c_scale_ff);
      end
   end

   // ---------------- result queue ----------------
   assign pop  = rsp_chan.valid && rsp_chan.ready;
   assign head = fifo_ff[rd_ptr_ff];

   // every word in flight has a queue slot reserved
   assign pending = (bfd_pkg::FIFO_CNT_W+1)'(fifo_cnt_ff) + (bfd_pkg::FIFO_CNT_W+1)'(c_valid_ff)
                    + (bfd_pkg::FIFO_CNT_W+1)'(b_valid_ff && b_emit_ff);
   assign req_chan.ready = pending < (bfd_pkg::FIFO_CNT_W+1)'(bfd_pkg::FIFO_DEPTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
      end else begin
         if (c_valid_ff) begin
            wr_ptr_ff <= wr_ptr_ff + bfd_pkg::FIFO_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + bfd_pkg::FIFO_PTR_W'(1);
         end
         if (c_valid_ff && !pop) begin
            fifo_cnt_ff <= fifo_cnt_ff + bfd_pkg::FIFO_CNT_W'(1);
         end else if (!c_valid_ff && pop) begin
            fifo_cnt_ff <= fifo_cnt_ff - bfd_pkg::FIFO_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (c_valid_ff) begin
         fifo_ff[wr_ptr_ff] <= c_word;
      end
   end

   assign rsp_chan.valid     = (fifo_cnt_ff != '0);
   assign rsp_chan.out_red   = head.chan[0];
   assign rsp_chan.out_green = head.chan[1];
   assign rsp_chan.out_blue  = head.chan[2];
   assign rsp_chan.out_alpha = head.chan[3];
   assign rsp_chan.row_end   = head.row_end;

endmodule

// ===== sv/bfd_checker.sv =====
`include "box_filter_downsample_macros.svh"

module bfd_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [bfd_pkg::CHAN_W-1:0]  rsp_red,
   input logic [bfd_pkg::CHAN_W-1:0]  rsp_green,
   input logic [bfd_pkg::CHAN_W-1:0]  rsp_blue,
   input logic [bfd_pkg::CHAN_W-1:0]  rsp_alpha,
   input logic                        rsp_row_end
);
   logic [4*bfd_pkg::CHAN_W:0] rsp_word;

   assign rsp_word = {rsp_row_end, rsp_alpha, rsp_blue, rsp_green, rsp_red};

   `BFD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid,
                    "result word dropped while stalled")
   `BFD_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_word),
                    "result word changed while stalled")
   // an empty output side fills only from a pixel taken earlier, through the RAM and divide stages
   `BFD_ASSERT_IMPL(a_first_latency, clock, reset, $rose(rsp_valid),
                    $past(req_valid && req_ready, 3), "result without a matching pixel")
   `BFD_ASSERT_IMPL(a_ready_after_reset, clock, reset, $fell(reset), req_ready,
                    "input not ready after reset")
endmodule

bind box_filter_downsample bfd_checker u_bfd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_red     (rsp_chan.out_red),
   .rsp_green   (rsp_chan.out_green),
   .rsp_blue    (rsp_chan.out_blue),
   .rsp_alpha   (rsp_chan.out_alpha),
   .rsp_row_end (rsp_chan.row_end)
);

// ===== test/box_filter_downsample_tb.sv =====
`timescale 1ns / 100ps

module box_filter_downsample_tb;

   localparam int RAND_ITEMS     = 1050;
   localparam int HOLDOFF        = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_CAP      = 200;

   // index with no register behind it, writes are dropped
   localparam bfd_pkg::csr_reg_type CSR_SPARE = bfd_pkg::csr_reg_type'(2'd3);

   typedef enum logic {ROW_PIXEL, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type                      kind;
      bfd_pkg::csr_reg_type              reg_idx;
      logic [bfd_pkg::CSR_DATA_W-1:0]    val;
      bfd_pkg::pixel_type                px;
      logic                              fs;
      bit                                typed;
      bfd_pkg::rsp_word_type             want;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset;

   bfd_req_if req_if();
   bfd_rsp_if rsp_if();
   bfd_csr_if csr_if();

   box_filter_downsample DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // shadow of the block: registers, band sums and position counters
   logic [bfd_pkg::FACTOR_W-1:0] fac_reg   = bfd_pkg::FACTOR_W'(bfd_pkg::FACTOR_RESET);
   logic [bfd_pkg::WIDTH_W-1:0]  width_reg = bfd_pkg::WIDTH_W'(bfd_pkg::WIDTH_RESET);
   int unsigned col_acc [bfd_pkg::MAX_OUT_WIDTH][bfd_pkg::NCHAN];
   int unsigned run_acc [bfd_pkg::NCHAN];
   int unsigned sub_col = 0;
   int unsigned sub_row = 0;
   int unsigned out_col = 0;

   bfd_pkg::rsp_word_type awaiting_avg[$];
   dir_row_type           dir_table[$];

   int          mismatch_cnt = 0;
   int          quiet_cycles = 0;
   int          burst_left   = 0;
   logic [5:0]  stall_tick   = '0;
   int          stall_mode   = 0;

   string chan_name[bfd_pkg::NCHAN] = '{"red", "green", "blue", "alpha"};

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned active_factor();
      if (fac_reg == 0) return 1;
      if (fac_reg > bfd_pkg::MAX_FACTOR) return bfd_pkg::MAX_FACTOR;
      return int'(fac_reg);
   endfunction

   function automatic int unsigned active_width();
      if (width_reg == 0) return 1;
      if (width_reg > bfd_pkg::MAX_OUT_WIDTH) return bfd_pkg::MAX_OUT_WIDTH;
      return int'(width_reg);
   endfunction

   // Advances the shadow by one pixel; returns 1 when a block average comes out.
   function automatic bit downsample_pixel(input bfd_pkg::pixel_type px, input logic fs,
                                           output bfd_pkg::rsp_word_type avg);
      int unsigned f;
      int unsigned w;
      int unsigned col;
      bit          done;
      f    = active_factor();
      w    = active_width();
      done = 1'b0;
      avg  = '0;
      if (fs) begin
         sub_col = 0;
         sub_row = 0;
         out_col = 0;
         for (int c = 0; c < bfd_pkg::NCHAN; c++) run_acc[c] = 0;
      end
      for (int c = 0; c < bfd_pkg::NCHAN; c++) run_acc[c] += px[c];
      if (sub_col + 1 >= f) begin
         // counters left past the limit by a register change count as at the limit
         col = (out_col >= w) ? w - 1 : out_col;
         for (int c = 0; c < bfd_pkg::NCHAN; c++) begin
            if (sub_row == 0) col_acc[col][c] = run_acc[c];
            else col_acc[col][c] += run_acc[c];
            run_acc[c] = 0;
         end
         if (sub_row + 1 >= f) begin
            for (int c = 0; c < bfd_pkg::NCHAN; c++)
               avg.chan[c] = bfd_pkg::CHAN_W'(col_acc[col][c] / (f * f));
            avg.row_end = (col + 1 >= w);
            done = 1'b1;
         end
         sub_col = 0;
         if (col + 1 >= w) begin
            out_col = 0;
            sub_row = (sub_row + 1 >= f) ? 0 : sub_row + 1;
         end else begin
            out_col = col + 1;
         end
      end else begin
         sub_col++;
      end
      return done;
   endfunction

   function automatic bfd_pkg::pixel_type rgba(input logic [7:0] r, g, b, a);
      return {a, b, g, r};
   endfunction

   function automatic dir_row_type row_px(input bfd_pkg::pixel_type px, input logic fs);
      dir_row_type row;
      row.kind    = ROW_PIXEL;
      row.reg_idx = bfd_pkg::CSR_FACTOR;
      row.val     = '0;
      row.px      = px;
      row.fs      = fs;
      row.typed   = 1'b0;
      row.want    = '0;
      return row;
   endfunction

   // pixel whose average is the pixel itself (factor 1, or a flat block)
   function automatic dir_row_type row_chk(input bfd_pkg::pixel_type px, input logic fs,
                                           input logic row_end);
      dir_row_type row;
      row              = row_px(px, fs);
      row.typed        = 1'b1;
      row.want.chan    = px;
      row.want.row_end = row_end;
      return row;
   endfunction

   function automatic dir_row_type row_csr(input bfd_pkg::csr_reg_type idx,
                                           input logic [bfd_pkg::CSR_DATA_W-1:0] val);
      dir_row_type row;
      row         = row_px('0, 1'b0);
      row.kind    = ROW_CSR;
      row.reg_idx = idx;
      row.val     = val;
      return row;
   endfunction

   function automatic logic [7:0] rand_chan();
      int sel;
      sel = $urandom_range(0, 7);
      if (sel == 0) return 8'h00;
      if (sel == 1) return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic report_bad(input string what, input int unsigned want,
                             input int unsigned got);
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
         $display("mismatch on %s: expected %0h, got %0h at %0t", what, want, got, $time);
   endtask

   // bursts of random length, random gaps in between
   task automatic pace_sender();
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   task automatic send_pixel(input bfd_pkg::pixel_type px, input logic fs, input bit typed,
                             input bfd_pkg::rsp_word_type want);
      bfd_pkg::rsp_word_type avg;
      bit                    has_avg;
      pace_sender();
      req_if.valid       <= 1'b1;
      req_if.in_red      <= px[0];
      req_if.in_green    <= px[1];
      req_if.in_blue     <= px[2];
      req_if.in_alpha    <= px[3];
      req_if.frame_start <= fs;
      do @(posedge clock); while (!req_if.ready);
      has_avg = downsample_pixel(px, fs, avg);
      if (typed) awaiting_avg.push_back(want);
      else if (has_avg) awaiting_avg.push_back(avg);
   endtask

   // block idle: nothing pending, and a partial block has had time to settle
   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (awaiting_avg.size() != 0) @(posedge clock);
      repeat (HOLDOFF) @(posedge clock);
   endtask

   task automatic write_reg(input bfd_pkg::csr_reg_type idx,
                            input logic [bfd_pkg::CSR_DATA_W-1:0] val);
      drain_results();
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= val;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      case (idx)
         bfd_pkg::CSR_FACTOR:    fac_reg   = val[bfd_pkg::FACTOR_W-1:0];
         bfd_pkg::CSR_OUT_WIDTH: width_reg = val[bfd_pkg::WIDTH_W-1:0];
         default: ;
      endcase
   endtask

   // receiver: a new stall mode each time the 6-bit tick counter wraps
   always @(posedge clock) begin
      stall_tick = stall_tick + 1'b1;
      if (stall_tick == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0:       rsp_if.ready <= 1'b1;
         1:       rsp_if.ready <= ($urandom_range(0, 3) != 0);
         2:       rsp_if.ready <= ($urandom_range(0, 3) == 0);
         default: rsp_if.ready <= stall_tick[2];
      endcase
   end

   always @(posedge clock) begin
      bfd_pkg::rsp_word_type want;
      bfd_pkg::pixel_type    got_px;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got_px = {rsp_if.out_alpha, rsp_if.out_blue, rsp_if.out_green, rsp_if.out_red};
         if (awaiting_avg.size() == 0) begin
            report_bad("word with nothing pending, red", 0, got_px[0]);
         end else begin
            want = awaiting_avg.pop_front();
            if (want.row_end !== rsp_if.row_end)
               report_bad("row_end", want.row_end, rsp_if.row_end);
            for (int c = 0; c < bfd_pkg::NCHAN; c++)
               if (want.chan[c] !== got_px[c]) report_bad(chan_name[c], want.chan[c], got_px[c]);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int                             n;
      int                             fe;
      int                             we;
      int                             sel;
      int                             rand_items;
      logic [bfd_pkg::FACTOR_W-1:0]   fac;
      logic [bfd_pkg::WIDTH_W-1:0]    wid;
      logic [bfd_pkg::CSR_DATA_W-1:0] fac_word;
      bfd_pkg::pixel_type             px;
      logic                           fs;

      reset              <= 1'b1;
      req_if.valid       <= 1'b0;
      req_if.in_red      <= '0;
      req_if.in_green    <= '0;
      req_if.in_blue     <= '0;
      req_if.in_alpha    <= '0;
      req_if.frame_start <= 1'b0;
      csr_if.valid       <= 1'b0;
      csr_if.index       <= bfd_pkg::CSR_FACTOR;
      csr_if.data        <= '0;

      // reset setting: factor 1, full width, so every pixel comes straight out
      dir_table.push_back(row_chk(rgba(8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b1, 1'b0));
      dir_table.push_back(row_chk(rgba(8'h00, 8'h00, 8'h00, 8'h00), 1'b0, 1'b0));
      dir_table.push_back(row_csr(CSR_SPARE, 11'h7FF));
      // zero factor and zero width both act as 1
      dir_table.push_back(row_csr(bfd_pkg::CSR_FACTOR, 11'd0));
      dir_table.push_back(row_csr(bfd_pkg::CSR_OUT_WIDTH, 11'd0));
      dir_table.push_back(row_chk(rgba(8'hA5, 8'h5A, 8'hC3, 8'h3C), 1'b1, 1'b1));
      // width past the maximum saturates, so no row end on column 0
      dir_table.push_back(row_csr(bfd_pkg::CSR_OUT_WIDTH, 11'h7FF));
      dir_table.push_back(row_chk(rgba(8'h3C, 8'hC3, 8'h5A, 8'hA5), 1'b1, 1'b0));
      // factor 7 saturates to 4: one flat 4x4 block, largest sums
      dir_table.push_back(row_csr(bfd_pkg::CSR_FACTOR, 11'd7));
      dir_table.push_back(row_csr(bfd_pkg::CSR_OUT_WIDTH, 11'd1));
      for (int i = 0; i < 15; i++)
         dir_table.push_back(row_px(rgba(8'hFF, 8'hFF, 8'hFF, 8'hFF), i == 0));
      dir_table.push_back(row_chk(rgba(8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b0, 1'b1));
      // factor drops to 2 with sub_column at 3: the counter wraps on the next pixel
      for (int i = 0; i < 3; i++)
         dir_table.push_back(row_px(rgba(8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b0));
      dir_table.push_back(row_csr(bfd_pkg::CSR_FACTOR, 11'd2));
      for (int i = 0; i < 3; i++)
         dir_table.push_back(row_px(rgba(8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b0));

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_table[i]) begin
         if (dir_table[i].kind == ROW_CSR)
            write_reg(dir_table[i].reg_idx, dir_table[i].val);
         else
            send_pixel(dir_table[i].px, dir_table[i].fs, dir_table[i].typed,
                       dir_table[i].want);
      end

      // random part: one setting per phase, each phase a frame of whole bands
      // unless capped, plus now and then a partial band and a stray frame start
      rand_items = 0;
      while (rand_items < RAND_ITEMS) begin
         sel = $urandom_range(0, 9);
         if (sel == 0) fac = '0;
         else if (sel == 1) fac = bfd_pkg::FACTOR_W'($urandom_range(5, 7));
         else fac = bfd_pkg::FACTOR_W'((sel - 2) % 4 + 1);
         sel = $urandom_range(0, 19);
         if (sel == 0) begin
            wid = '0;
         end else if (sel == 1) begin
            // wide rows only make results at factor 1
            wid = bfd_pkg::WIDTH_W'($urandom_range(bfd_pkg::MAX_OUT_WIDTH, 2047));
            fac = bfd_pkg::FACTOR_W'($urandom_range(0, 1));
         end else if (sel < 6) begin
            wid = bfd_pkg::WIDTH_W'($urandom_range(9, 40));
         end else begin
            wid = bfd_pkg::WIDTH_W'($urandom_range(1, 8));
         end
         // upper data bits are not part of the factor field
         fac_word = bfd_pkg::CSR_DATA_W'(($urandom_range(0, 255) << bfd_pkg::FACTOR_W) | fac);
         if ($urandom_range(0, 1) == 0) begin
            write_reg(bfd_pkg::CSR_FACTOR, fac_word);
            write_reg(bfd_pkg::CSR_OUT_WIDTH, wid);
         end else begin
            write_reg(bfd_pkg::CSR_OUT_WIDTH, wid);
            write_reg(bfd_pkg::CSR_FACTOR, fac_word);
         end
         fe = active_factor();
         we = active_width();
         n  = fe * fe * we * $urandom_range(1, 3);
         if ($urandom_range(0, 2) == 0) n += $urandom_range(1, fe * we);
         if (n > PHASE_CAP) n = PHASE_CAP;
         if (n > RAND_ITEMS - rand_items) n = RAND_ITEMS - rand_items;
         for (int i = 0; i < n; i++) begin
            px = rgba(rand_chan(), rand_chan(), rand_chan(), rand_chan());
            fs = (i == 0) || ($urandom_range(0, 49) == 0);
            send_pixel(px, fs, 1'b0, '0);
         end
         rand_items += n;
      end

      drain_results();
      if (mismatch_cnt == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+sv
sv/bfd_pkg.sv
sv/bfd_channels.sv
sv/bfd_ram.sv
sv/box_filter_downsample.sv
sv/bfd_checker.sv
test/box_filter_downsample_tb.sv
